// ----- hw/rtl/tlca_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tlca_pkg: shared types and constants for the tree LCA engine
// Sizes, request codes and sequencer states.
// ---------------------------------------------------------------------------
package tlca_pkg;

	localparam int MAX_NODES  = 1024;
	localparam int LOG_LEVELS = 10;
	localparam int NODE_W     = $clog2(MAX_NODES);
	localparam int LVL_W      = $clog2(LOG_LEVELS + 1);
	localparam int DEPTH_W    = 10;
	localparam int PARENT_W   = NODE_W + 1;
	localparam int DIST_W     = 11;
	localparam int COUNT_W    = 11;
	localparam int IN_W       = 56;
	localparam int OUT_W      = 24;
	localparam int ANC_DEPTH  = LOG_LEVELS * MAX_NODES;
	localparam int ANC_AW     = $clog2(ANC_DEPTH);

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_BUILD = 2'd1,
		OP_QUERY = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_B_RD,
		ST_B_CHK,
		ST_B_WR,
		ST_Q_DX,
		ST_Q_DY,
		ST_Q_SW,
		ST_Q_UP,
		ST_Q_UPW,
		ST_Q_EQ,
		ST_Q_DN,
		ST_Q_DNU,
		ST_Q_DNV,
		ST_Q_L0,
		ST_Q_L0W,
		ST_Q_DW,
		ST_Q_DC
	} state_t;

endpackage
`default_nettype wire

// ----- hw/rtl/tree_lca_binary_lifting.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tree_lca_binary_lifting: lowest common ancestor engine, binary lifting
// One sequencer drives an ancestor memory and a depth memory.
// ---------------------------------------------------------------------------
// Usage:
//  Requests enter on s_t*, one at a time (s_tready low while busy).
//  Load request: writes a node's parent and depth in the accept cycle.
//  Build request: fills ancestor levels 1..9 for the first node_count nodes
//  (at most 1024); an entry whose ancestor is none is copied up, else that
//  ancestor's entry is read first. node_count of zero makes it a no-op.
//  Query request: three LCA walks (u,v), (u,a), (a,v) on one shared read
//  port; a walk reads both depths, lifts the deeper node over the depth gap
//  level by level (one ancestor read per set bit), compares the two nodes,
//  does the joint descent and last step if the nodes still differ, and
//  reads the LCA depth. The walks run one after another, since the
//  ancestor memory has a single read port.
//  The result goes to an output register on m_t*; the engine returns to
//  idle and takes new requests while the result waits. A later query
//  holds in its last cycle until the output register is free.
//  Reset clears control state and sets node_count to 1024; memory contents
//  are undefined until loaded.
//  cfg_we/cfg_wdata write node_count; write only while idle.
// ---------------------------------------------------------------------------
module tree_lca_binary_lifting (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           s_tvalid,
	output logic                          s_tready,
	// operation[1:0], node[11:2], parent_node[22:12], depth[32:23],
	// other_node[42:33], path_node[52:43], zero fill
	input  wire  [tlca_pkg::IN_W-1:0]     s_tdata,
	output logic                          m_tvalid,
	input  wire                           m_tready,
	// lca_node[9:0], distance[20:10], on_path[21], zero fill
	output logic [tlca_pkg::OUT_W-1:0]    m_tdata,
	input  wire                           cfg_we,
	input  wire  [tlca_pkg::COUNT_W-1:0]  cfg_wdata
);
	import tlca_pkg::*;

	// request fields
	op_t                 in_op;
	logic [NODE_W-1:0]   in_node, in_other, in_path;
	logic [PARENT_W-1:0] in_parent;
	logic [DEPTH_W-1:0]  in_depth;

	assign in_op     = op_t'(s_tdata[1:0]);
	assign in_node   = s_tdata[11:2];
	assign in_parent = s_tdata[22:12];
	assign in_depth  = s_tdata[32:23];
	assign in_other  = s_tdata[42:33];
	assign in_path   = s_tdata[52:43];

	state_t state_q, state_d;

	logic [COUNT_W-1:0]  node_count_q;
	logic [COUNT_W-1:0]  n_eff;
	logic [COUNT_W-1:0]  x_q;          // build node counter
	logic [LVL_W-1:0]    k_q;          // level counter
	logic [NODE_W-1:0]   qu_q, qv_q, qa_q;
	logic [1:0]          pair_q;       // 0:(u,v) 1:(u,a) 2:(a,v)
	logic [NODE_W-1:0]   px, py;
	logic [NODE_W-1:0]   wu_q, wv_q, w_q;
	logic [DEPTH_W-1:0]  du_q, dv_q, diff_q;
	logic [PARENT_W-1:0] pu_q;
	logic [DIST_W-1:0]   d0_q, d1_q;
	logic [NODE_W-1:0]   lca_q;

	// output register
	logic                out_valid_q;
	logic [NODE_W-1:0]   out_lca_q;
	logic [DIST_W-1:0]   out_dist_q;
	logic                out_on_q;

	// memories: ancestor entry bit 10 marks "none" (root)
	logic [PARENT_W-1:0] anc_mem [0:ANC_DEPTH-1];
	logic [DEPTH_W-1:0]  dep_mem [0:MAX_NODES-1];
	logic                anc_we, dep_we;
	logic [ANC_AW-1:0]   anc_waddr, anc_raddr;
	logic [PARENT_W-1:0] anc_wdata, anc_rdata_q;
	logic [NODE_W-1:0]   dep_waddr, dep_raddr;
	logic [DEPTH_W-1:0]  dep_wdata, dep_rdata_q;

	logic                anc_none;
	logic [NODE_W-1:0]   anc_p;
	logic                build_adv, build_last, final_go;
	logic [DIST_W:0]     dsum, dtwo;
	logic [DIST_W-1:0]   dcur;
	logic [DIST_W:0]     on_sum;

	assign anc_none = anc_rdata_q[PARENT_W-1];
	assign anc_p    = anc_rdata_q[NODE_W-1:0];
	assign n_eff    = (node_count_q > COUNT_W'(MAX_NODES)) ? COUNT_W'(MAX_NODES)
	                                                        : node_count_q;

	always_comb begin
		case (pair_q)
			2'd0:    begin px = qu_q; py = qv_q; end
			2'd1:    begin px = qu_q; py = qa_q; end
			default: begin px = qa_q; py = qv_q; end
		endcase
	end

	// distance of current walk: du + dv - 2*dw, floored at zero
	assign dsum = (DIST_W+1)'(du_q) + (DIST_W+1)'(dv_q);
	assign dtwo = {1'b0, dep_rdata_q, 1'b0};
	assign dcur = (dsum < dtwo) ? '0 : DIST_W'(dsum - dtwo);
	assign on_sum = (DIST_W+1)'(d1_q) + (DIST_W+1)'(dcur);

	assign build_last = (x_q + 1'b1 == n_eff) && (k_q == LVL_W'(LOG_LEVELS - 2));
	assign final_go   = !out_valid_q || m_tready;

	always_ff @(posedge clk) begin
		if (anc_we) anc_mem[anc_waddr] <= anc_wdata;
		anc_rdata_q <= anc_mem[anc_raddr];
	end

	always_ff @(posedge clk) begin
		if (dep_we) dep_mem[dep_waddr] <= dep_wdata;
		dep_rdata_q <= dep_mem[dep_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// sequencer: next state and memory controls
	always_comb begin
		state_d   = state_q;
		s_tready  = (state_q == ST_IDLE);
		anc_we    = 1'b0;
		anc_waddr = '0;
		anc_wdata = '0;
		anc_raddr = '0;
		dep_we    = 1'b0;
		dep_waddr = '0;
		dep_wdata = '0;
		dep_raddr = '0;
		build_adv = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					case (in_op)
						OP_LOAD: begin
							anc_we    = 1'b1;
							anc_waddr = {LVL_W'(0), in_node};
							anc_wdata = in_parent;
							dep_we    = 1'b1;
							dep_waddr = in_node;
							dep_wdata = in_depth;
						end
						OP_BUILD: if (n_eff != '0) state_d = ST_B_RD;
						OP_QUERY: state_d = ST_Q_DX;
						default: ;
					endcase
				end
			end
			ST_B_RD: begin
				anc_raddr = {k_q, x_q[NODE_W-1:0]};
				state_d   = ST_B_CHK;
			end
			ST_B_CHK: begin
				if (anc_none) begin
					anc_we    = 1'b1;
					anc_waddr = {k_q + 1'b1, x_q[NODE_W-1:0]};
					anc_wdata = anc_rdata_q;
					build_adv = 1'b1;
					state_d   = build_last ? ST_IDLE : ST_B_RD;
				end else begin
					anc_raddr = {k_q, anc_p};
					state_d   = ST_B_WR;
				end
			end
			ST_B_WR: begin
				anc_we    = 1'b1;
				anc_waddr = {k_q + 1'b1, x_q[NODE_W-1:0]};
				anc_wdata = anc_rdata_q;
				build_adv = 1'b1;
				state_d   = build_last ? ST_IDLE : ST_B_RD;
			end
			ST_Q_DX: begin
				dep_raddr = px;
				state_d   = ST_Q_DY;
			end
			ST_Q_DY: begin
				dep_raddr = py;
				state_d   = ST_Q_SW;
			end
			ST_Q_SW: state_d = ST_Q_UP;
			ST_Q_UP: begin
				if (k_q == LVL_W'(LOG_LEVELS)) begin
					state_d = ST_Q_EQ;
				end else if (diff_q[k_q]) begin
					anc_raddr = {k_q, wu_q};
					state_d   = ST_Q_UPW;
				end
			end
			ST_Q_UPW: state_d = ST_Q_UP;
			ST_Q_EQ: state_d = (wu_q == wv_q) ? ST_Q_DW : ST_Q_DN;
			ST_Q_DN: begin
				anc_raddr = {k_q, wu_q};
				state_d   = ST_Q_DNU;
			end
			ST_Q_DNU: begin
				anc_raddr = {k_q, wv_q};
				state_d   = ST_Q_DNV;
			end
			ST_Q_DNV: state_d = (k_q == '0) ? ST_Q_L0 : ST_Q_DN;
			ST_Q_L0: begin
				anc_raddr = {LVL_W'(0), wu_q};
				state_d   = ST_Q_L0W;
			end
			ST_Q_L0W: state_d = ST_Q_DW;
			ST_Q_DW: begin
				dep_raddr = w_q;
				state_d   = ST_Q_DC;
			end
			ST_Q_DC: begin
				dep_raddr = w_q;    // hold depth while waiting on output
				if (pair_q != 2'd2) state_d = ST_Q_DX;
				else if (final_go)  state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// working registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				x_q    <= '0;
				k_q    <= '0;
				pair_q <= 2'd0;
				qu_q   <= in_node;
				qv_q   <= in_other;
				qa_q   <= in_path;
			end
			ST_B_CHK, ST_B_WR: begin
				if (build_adv) begin
					if (x_q + 1'b1 == n_eff) begin
						x_q <= '0;
						k_q <= k_q + 1'b1;
					end else begin
						x_q <= x_q + 1'b1;
					end
				end
			end
			ST_Q_DY: du_q <= dep_rdata_q;
			ST_Q_SW: begin
				dv_q <= dep_rdata_q;
				k_q  <= '0;
				if (du_q < dep_rdata_q) begin
					wu_q   <= py;
					wv_q   <= px;
					diff_q <= dep_rdata_q - du_q;
				end else begin
					wu_q   <= px;
					wv_q   <= py;
					diff_q <= du_q - dep_rdata_q;
				end
			end
			ST_Q_UP: begin
				if (k_q != LVL_W'(LOG_LEVELS) && !diff_q[k_q]) k_q <= k_q + 1'b1;
			end
			ST_Q_UPW: begin
				if (!anc_none) wu_q <= anc_p;
				k_q <= k_q + 1'b1;
			end
			ST_Q_EQ: begin
				w_q <= wu_q;
				k_q <= LVL_W'(LOG_LEVELS - 1);
			end
			ST_Q_DNU: pu_q <= anc_rdata_q;
			ST_Q_DNV: begin
				if (!pu_q[PARENT_W-1] && !anc_none && pu_q != anc_rdata_q) begin
					wu_q <= pu_q[NODE_W-1:0];
					wv_q <= anc_p;
				end
				if (k_q != '0) k_q <= k_q - 1'b1;
			end
			ST_Q_L0W: w_q <= anc_none ? wu_q : anc_p;
			ST_Q_DC: begin
				if (pair_q == 2'd0) begin
					d0_q  <= dcur;
					lca_q <= w_q;
				end
				if (pair_q == 2'd1) d1_q <= dcur;
				if (pair_q != 2'd2) pair_q <= pair_q + 1'b1;
			end
			default: ;
		endcase
	end

	// node_count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)     node_count_q <= COUNT_W'(1024);
		else if (cfg_we) node_count_q <= cfg_wdata;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_Q_DC && pair_q == 2'd2 && final_go) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_Q_DC && pair_q == 2'd2 && final_go) begin
			out_lca_q  <= lca_q;
			out_dist_q <= d0_q;
			out_on_q   <= (on_sum == (DIST_W+1)'(d0_q));
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_on_q, out_dist_q, out_lca_q};

endmodule
`default_nettype wire

// ----- hw/rtl/tlca_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tlca_checker: port-level checks for the tree LCA engine
// Watches the request and result channels; bound to the top level.
// ---------------------------------------------------------------------------
module tlca_checker (
	input wire                        clk,
	input wire                        arst_n,
	input wire                        s_tvalid,
	input wire                        s_tready,
	input wire [tlca_pkg::IN_W-1:0]   s_tdata,
	input wire                        m_tvalid,
	input wire                        m_tready,
	input wire [tlca_pkg::OUT_W-1:0]  m_tdata
);
	import tlca_pkg::*;

	// stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed under stall");

	// a query keeps the engine busy
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tdata[1:0] == OP_QUERY |=> !s_tready)
		else $error("ready right after query");

	// loads finish in the accept cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tdata[1:0] == OP_LOAD |=> s_tready)
		else $error("load stalled the engine");

	// a new result only shows up at the end of busy work
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result without busy phase");

endmodule

bind tree_lca_binary_lifting tlca_checker u_tlca_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire
